### hw/rtl/toc_pkg.sv
package toc_pkg;

    localparam int MAX_CITIES = 64;
    localparam int MIN_CITIES = 2;

    localparam int CITY_W = 6;
    localparam int CFG_W  = 7;
    localparam int POS_W  = $clog2(MAX_CITIES);
    localparam int CNT_W  = POS_W + 1;
    localparam int NUM_CITY_IDS = 1 << CITY_W;

    localparam logic [CFG_W-1:0] CITY_COUNT_RESET = CFG_W'(MAX_CITIES);

    typedef enum logic [1:0] {
        FAULT_OK        = 2'd0,
        FAULT_BOUNDS    = 2'd1,
        FAULT_EXHAUSTED = 2'd2
    } t_fault;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MARK,
        S_RD,
        S_CHK
    } t_state;

endpackage

### hw/rtl/tour_order_crossover.sv
// channel   | direction | handshake              | payload
// ----------+-----------+------------------------+-------------------------------------------
// request   | in        | start, busy            | first/second city, seg start/end, last_in
// result    | out       | o_strobe (one cycle)   | child city, last_out, fault
// config    | in        | i_cfg_wr_en            | i_cfg_wr_data (city count)
//
// a load request without last_in leaves busy low
// a run marks the segment through the single parent memory read port, then copies each
// segment position from the first parent, scans second-parent entries for unmarked cities,
// and gives a zero city with an exhausted fault for each slot left once the scan runs out
// synchronous reset clears control state and sets the city count to 64; parent memory contents stay undefined
// results cannot be stalled; the start-beyond-end fault comes in the cycle after the request
module tour_order_crossover (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [toc_pkg::CITY_W-1:0]  i_first_city,
    input  logic [toc_pkg::CITY_W-1:0]  i_second_city,
    input  logic [toc_pkg::CITY_W-1:0]  i_seg_start,
    input  logic [toc_pkg::CITY_W-1:0]  i_seg_end,
    input  logic                        i_last_in,
    input  logic                        i_cfg_wr_en,
    input  logic [toc_pkg::CFG_W-1:0]   i_cfg_wr_data,
    output logic                        o_strobe,
    output logic [toc_pkg::CITY_W-1:0]  o_child_city,
    output logic                        o_last_out,
    output logic [1:0]                  o_fault
);

    localparam int CITY_W = toc_pkg::CITY_W;
    localparam int CFG_W  = toc_pkg::CFG_W;
    localparam int POS_W  = toc_pkg::POS_W;
    localparam int CNT_W  = toc_pkg::CNT_W;
    localparam int IDS    = toc_pkg::NUM_CITY_IDS;
    localparam logic [CNT_W-1:0] LOAD_FULL = CNT_W'(toc_pkg::MAX_CITIES);
    localparam logic [CFG_W-1:0] CNT_MAX   = CFG_W'(toc_pkg::MAX_CITIES);
    localparam logic [CFG_W-1:0] CNT_MIN   = CFG_W'(toc_pkg::MIN_CITIES);

    toc_pkg::t_state r_state, n_state;

    logic [CFG_W-1:0]  r_city_count;
    logic [CNT_W-1:0]  r_load_pos, n_load_pos;
    logic [CNT_W-1:0]  r_n, n_n;
    logic [CNT_W-1:0]  r_start, n_start;
    logic [CNT_W-1:0]  r_end, n_end;
    logic [CNT_W-1:0]  r_pos, n_pos;
    logic [CNT_W-1:0]  r_scan, n_scan;
    logic [IDS-1:0]    r_marks, n_marks;
    logic              r_rv, n_rv;
    logic              r_strobe, n_strobe;
    logic [CITY_W-1:0] r_city, n_city;
    logic              r_last, n_last;
    logic [1:0]        r_fault, n_fault;

    logic                   ram_we;
    logic [POS_W-1:0]       ram_raddr;
    logic [2*CITY_W-1:0]    ram_q;
    logic [CITY_W-1:0]      q_first, q_second;

    logic             accept;
    logic [CFG_W-1:0] run_len, end_clamp;
    logic             seg_bad;
    logic             in_seg, exhausted, pos_last, mark_issue, city_free;

    assign busy     = (r_state != toc_pkg::S_IDLE);
    assign accept   = start && !busy;
    assign q_first  = ram_q[2*CITY_W-1:CITY_W];
    assign q_second = ram_q[CITY_W-1:0];

    always_comb begin
        if (r_city_count < CNT_MIN) begin
            run_len = CNT_MIN;
        end else if (r_city_count > CNT_MAX) begin
            run_len = CNT_MAX;
        end else begin
            run_len = r_city_count;
        end
        end_clamp = (CFG_W'(i_seg_end) > run_len) ? run_len : CFG_W'(i_seg_end);
        seg_bad   = CFG_W'(i_seg_start) > end_clamp;
    end

    assign in_seg     = (r_pos >= r_start) && (r_pos < r_end);
    assign exhausted  = (r_scan >= r_n);
    assign pos_last   = ((r_pos + CNT_W'(1)) == r_n);
    assign mark_issue = (r_pos < r_end);
    assign city_free  = !r_marks[q_second];

    assign ram_we = accept && (r_load_pos != LOAD_FULL);

    toc_ram #(
        .DATA_W (2 * CITY_W),
        .ADDR_W (POS_W)
    ) u_parent_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (r_load_pos[POS_W-1:0]),
        .i_wr_data ({i_first_city, i_second_city}),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_q)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            toc_pkg::S_IDLE: begin
                if (accept && i_last_in && !seg_bad) n_state = toc_pkg::S_MARK;
            end
            toc_pkg::S_MARK: begin
                if (!mark_issue && !r_rv) n_state = toc_pkg::S_RD;
            end
            toc_pkg::S_RD: begin
                if (!in_seg && exhausted) begin
                    if (pos_last) n_state = toc_pkg::S_IDLE;
                end else begin
                    n_state = toc_pkg::S_CHK;
                end
            end
            toc_pkg::S_CHK: begin
                if ((in_seg || city_free) && pos_last) n_state = toc_pkg::S_IDLE;
                else n_state = toc_pkg::S_RD;
            end
            default: n_state = toc_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_load_pos = r_load_pos;
        n_n        = r_n;
        n_start    = r_start;
        n_end      = r_end;
        n_pos      = r_pos;
        n_scan     = r_scan;
        n_marks    = r_marks;
        n_rv       = 1'b0;
        n_strobe   = 1'b0;
        n_city     = r_city;
        n_last     = 1'b0;
        n_fault    = r_fault;
        ram_raddr  = r_pos[POS_W-1:0];
        unique case (r_state)
            toc_pkg::S_IDLE: begin
                if (accept) begin
                    if (r_load_pos != LOAD_FULL) n_load_pos = r_load_pos + CNT_W'(1);
                    if (i_last_in) begin
                        n_load_pos = '0;
                        n_n        = CNT_W'(run_len);
                        n_start    = CNT_W'(i_seg_start);
                        n_end      = CNT_W'(end_clamp);
                        n_pos      = CNT_W'(i_seg_start);
                        n_marks    = '0;
                        if (seg_bad) begin
                            n_strobe = 1'b1;
                            n_city   = '0;
                            n_last   = 1'b1;
                            n_fault  = toc_pkg::FAULT_BOUNDS;
                        end
                    end
                end
            end
            toc_pkg::S_MARK: begin
                // read one segment entry per cycle, mark it when the data returns
                if (mark_issue) begin
                    n_pos = r_pos + CNT_W'(1);
                    n_rv  = 1'b1;
                end
                if (r_rv) n_marks[q_first] = 1'b1;
                if (!mark_issue && !r_rv) begin
                    n_pos  = '0;
                    n_scan = '0;
                end
            end
            toc_pkg::S_RD: begin
                if (in_seg) begin
                    ram_raddr = r_pos[POS_W-1:0];
                end else begin
                    ram_raddr = r_scan[POS_W-1:0];
                    if (exhausted) begin
                        n_strobe = 1'b1;
                        n_city   = '0;
                        n_last   = pos_last;
                        n_fault  = toc_pkg::FAULT_EXHAUSTED;
                        n_pos    = r_pos + CNT_W'(1);
                    end
                end
            end
            toc_pkg::S_CHK: begin
                if (in_seg) begin
                    n_strobe = 1'b1;
                    n_city   = q_first;
                    n_last   = pos_last;
                    n_fault  = toc_pkg::FAULT_OK;
                    n_pos    = r_pos + CNT_W'(1);
                end else begin
                    // scan pointer only moves forward, earlier entries stay placed
                    n_scan = r_scan + CNT_W'(1);
                    if (city_free) begin
                        n_marks[q_second] = 1'b1;
                        n_strobe = 1'b1;
                        n_city   = q_second;
                        n_last   = pos_last;
                        n_fault  = toc_pkg::FAULT_OK;
                        n_pos    = r_pos + CNT_W'(1);
                    end
                end
            end
            default: begin
                n_rv = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= toc_pkg::S_IDLE;
            r_city_count <= toc_pkg::CITY_COUNT_RESET;
            r_load_pos   <= '0;
            r_marks      <= '0;
            r_rv         <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_load_pos <= n_load_pos;
            r_marks    <= n_marks;
            r_rv       <= n_rv;
            r_strobe   <= n_strobe;
            if (i_cfg_wr_en) r_city_count <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n     <= n_n;
        r_start <= n_start;
        r_end   <= n_end;
        r_pos   <= n_pos;
        r_scan  <= n_scan;
        r_city  <= n_city;
        r_last  <= n_last;
        r_fault <= n_fault;
    end

    assign o_strobe     = r_strobe;
    assign o_child_city = r_city;
    assign o_last_out   = r_last;
    assign o_fault      = r_fault;

endmodule

### hw/rtl/toc_ram.sv
module toc_ram #(
    parameter int DATA_W = 12,
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/toc_checker.sv
module toc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        i_last_in,
    input logic                        o_strobe,
    input logic [toc_pkg::CITY_W-1:0]  o_child_city,
    input logic                        o_last_out,
    input logic [1:0]                  o_fault
);

    // the final result of a run shows with the block already free
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last_out |-> !busy)
        else $error("busy still high on final result");

    // results before the final one come while the run is in progress
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last_out |-> busy)
        else $error("intermediate result while idle");

    a_bounds_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_fault == toc_pkg::FAULT_BOUNDS) |-> o_last_out && (o_child_city == '0))
        else $error("bounds fault not a lone zero result");

    a_exhaust_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_fault == toc_pkg::FAULT_EXHAUSTED) |-> (o_child_city == '0))
        else $error("exhausted slot carries a city");

    // a plain load request never produces a result
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && !i_last_in |=> !o_strobe)
        else $error("result after load request");

endmodule

bind tour_order_crossover toc_checker u_toc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_last_in    (i_last_in),
    .o_strobe     (o_strobe),
    .o_child_city (o_child_city),
    .o_last_out   (o_last_out),
    .o_fault      (o_fault)
);
